// File: design/sewd_pkg.sv
// ----------------------------------------------------------------------------
// sewd_pkg
// Shared types, codes and word compare functions of the word dictionary.
// ----------------------------------------------------------------------------
package sewd_pkg;

  localparam int CAPACITY_DEF = 64;
  localparam int MAX_LEN_DEF  = 10;
  localparam int WORD_BYTES   = 10;

  typedef enum logic [2:0] {
    CMD_ADD         = 3'd0,
    CMD_SEARCH      = 3'd1,
    CMD_REPLACE     = 3'd2,
    CMD_SWAP        = 3'd3,
    CMD_MAX_REPLACE = 3'd4,
    CMD_MAX_SWAP    = 3'd5
  } cmd_t;

  typedef enum logic [3:0] {
    ST_ADDED      = 4'd0,
    ST_DUPLICATE  = 4'd1,
    ST_FULL       = 4'd2,
    ST_BAD_LENGTH = 4'd3,
    ST_FOUND      = 4'd4,
    ST_NOT_FOUND  = 4'd5,
    ST_MATCH      = 4'd6,
    ST_NO_MATCH   = 4'd7,
    ST_COUNT      = 4'd8
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_COUNT,
    S_MAX,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_ROTATE,
    CELL_INSERT,
    CELL_CLEAR
  } cell_op_t;

  typedef struct packed {
    logic [3:0]  len;
    logic [63:0] head;
    logic [15:0] tail;
  } word_t;

  typedef struct packed {
    cell_op_t op;
    logic     swap_mode;
    logic     count_en;
  } cell_ctrl_t;

  function automatic logic [7:0] byte_of(word_t w, int i);
    logic [79:0] bits;
    bits = {w.head, w.tail};
    return bits[79 - 8 * i -: 8];
  endfunction

  // at most one byte position differs
  function automatic logic near_replace(word_t a, word_t b);
    logic [3:0] n;
    n = '0;
    for (int i = 0; i < WORD_BYTES; i++) begin
      if (byte_of(a, i) != byte_of(b, i)) n = n + 4'd1;
    end
    return n <= 4'd1;
  endfunction

  // exactly one adjacent swap of k gives t
  function automatic logic near_swap(word_t k, word_t t);
    logic [WORD_BYTES-1:0] eq;
    logic [WORD_BYTES-2:0] same;
    logic [3:0]            n;
    for (int i = 0; i < WORD_BYTES; i++) eq[i] = byte_of(k, i) == byte_of(t, i);
    n = '0;
    for (int j = 0; j < WORD_BYTES - 1; j++) begin
      same[j] = (4'(j + 1) < k.len) && (byte_of(k, j + 1) == byte_of(t, j)) &&
                (byte_of(k, j) == byte_of(t, j + 1));
      for (int i = 0; i < WORD_BYTES; i++) begin
        if (i != j && i != j + 1) same[j] = same[j] & eq[i];
      end
      if (same[j]) n = n + 4'd1;
    end
    return n == 4'd1;
  endfunction

  function automatic logic word_hit(logic swap_mode, word_t a, word_t b);
    return (a.len == b.len) && (swap_mode ? near_swap(a, b) : near_replace(a, b));
  endfunction

endpackage

// File: design/sewd_if.sv
// ----------------------------------------------------------------------------
// sewd_if
// Request and response channels of the word dictionary.
// ----------------------------------------------------------------------------
interface sewd_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  command;
  logic [3:0]  word_length;
  logic [63:0] word_head;
  logic [15:0] word_tail;
  modport source (output valid, command, word_length, word_head, word_tail, input ready);
  modport sink (input valid, command, word_length, word_head, word_tail, output ready);
endinterface

interface sewd_rsp_if;
  logic              valid;
  logic              ready;
  logic [3:0]        status;
  logic [3:0]        match_length;
  logic [63:0]       match_head;
  logic [15:0]       match_tail;
  logic signed [7:0] best_count;
  logic              last;
  modport source (output valid, status, match_length, match_head, match_tail, best_count,
                  last, input ready);
  modport sink (input valid, status, match_length, match_head, match_tail, best_count,
                last, output ready);
endinterface

// File: design/sewd_cell.sv
// ----------------------------------------------------------------------------
// sewd_cell
// One slot of the word ring: holds a word and its neighbor count.
// ----------------------------------------------------------------------------
module sewd_cell #(
  parameter int CAPACITY = 64,
  parameter int INDEX    = 0,
  localparam int IDX_W   = $clog2(CAPACITY),
  localparam int CNT_W   = $clog2(CAPACITY + 1)
) (
  input  logic               clk,
  input  sewd_pkg::cell_ctrl_t ctrl,
  input  logic [IDX_W-1:0]   step,
  input  logic [CNT_W-1:0]   count,
  input  sewd_pkg::word_t    key,
  input  sewd_pkg::word_t    up,
  input  logic [CNT_W-1:0]   up_cnt,
  input  sewd_pkg::word_t    down,
  input  logic               down_gt,
  output sewd_pkg::word_t    word,
  output logic [CNT_W-1:0]   cnt,
  output logic [CNT_W-1:0]   cnt_pass,
  output logic               gt
);
  import sewd_pkg::*;

  logic [IDX_W:0] pos_sum;
  logic [IDX_W:0] pos;
  logic           own_valid;
  logic           at_end;
  logic           inc;

  always_comb begin
    pos_sum   = (IDX_W + 1)'(INDEX) + {1'b0, step};
    pos       = (pos_sum >= (IDX_W + 1)'(CAPACITY)) ? pos_sum - (IDX_W + 1)'(CAPACITY)
                                                    : pos_sum;
    own_valid = pos < (IDX_W + 1)'(count);
    at_end    = (IDX_W + 1)'(INDEX) == (IDX_W + 1)'(count);
    gt        = own_valid && ({word.head, word.tail, word.len} > {key.head, key.tail, key.len});
    inc       = ctrl.count_en && own_valid && word_hit(ctrl.swap_mode, word, key);
    cnt_pass  = cnt + CNT_W'(inc);
  end

  always_ff @(posedge clk) begin
    case (ctrl.op)
      CELL_ROTATE: begin
        word <= up;
        cnt  <= up_cnt;
      end
      CELL_INSERT: begin
        if (down_gt) begin
          word <= down;
        end else if (gt || at_end) begin
          word <= key;
        end
      end
      CELL_CLEAR: cnt <= '0;
      default: ;
    endcase
  end

endmodule

// File: design/single_edit_word_dictionary_core.sv
// ----------------------------------------------------------------------------
// single_edit_word_dictionary_core
// Sorted word store kept in a ring of cells, with replace and swap queries.
//
//   channel   | dir | payload
//   ----------+-----+-------------------------------------------------------
//   request   | in  | command, word_length, word_head, word_tail
//   response  | out | status, match_length, match_head, match_tail,
//             |     | best_count, last
//
// add, search, replace and swap queries: one ring turn
// bad length on add, search, replace or swap: no ring turn
// max counts: one ring turn to count, one for max
// for add, search, replace and swap, a full ring turn is set by the single compare point at cell 0
// reset clears the word count and control; stored words are not cleared
// a stalled response pauses the ring during a query run
// ----------------------------------------------------------------------------
module single_edit_word_dictionary_core #(
  parameter int CAPACITY = sewd_pkg::CAPACITY_DEF,
  parameter int MAX_LEN  = sewd_pkg::MAX_LEN_DEF
) (
  input logic      clk,
  input logic      rst,
  sewd_req_if.sink request,
  sewd_rsp_if.source response
);
  import sewd_pkg::*;

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);

  state_t           state;
  state_t           state_next;
  cmd_t             cmd;
  word_t            query;
  word_t            query_in;
  logic             badlen;
  logic             present;
  logic             pend_valid;
  word_t            pend;
  logic [IDX_W-1:0] step;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] best;

  logic              out_valid;
  logic [3:0]        out_status;
  logic [3:0]        out_length;
  logic [63:0]       out_head;
  logic [15:0]       out_tail;
  logic signed [7:0] out_best;
  logic              out_last;

  word_t            cell_word [CAPACITY];
  logic [CNT_W-1:0] cell_cnt  [CAPACITY];
  logic [CNT_W-1:0] cell_pass [CAPACITY];
  logic             cell_gt   [CAPACITY];
  cell_ctrl_t       ctrl;
  word_t            key;

  logic  accept;
  logic  in_bad;
  word_t head;
  logic  head_valid;
  logic  last_step;
  logic  out_free;
  logic  is_query;
  logic  scan_hit;
  logic  stall;
  logic  advance;
  logic  do_insert;
  logic  emit;

  always_comb begin
    query_in.len = request.word_length;
    for (int i = 0; i < 8; i++) begin
      query_in.head[63 - 8 * i -: 8] = (4'(i) < request.word_length) ?
                                       request.word_head[63 - 8 * i -: 8] : 8'd0;
    end
    for (int i = 0; i < 2; i++) begin
      query_in.tail[15 - 8 * i -: 8] = (4'(i + 8) < request.word_length) ?
                                       request.word_tail[15 - 8 * i -: 8] : 8'd0;
    end
    in_bad = (request.word_length == 4'd0) || (request.word_length > 4'(MAX_LEN));
  end

  always_comb begin
    accept     = request.valid && request.ready;
    head       = cell_word[0];
    head_valid = CNT_W'(step) < count;
    last_step  = step == IDX_W'(CAPACITY - 1);
    out_free   = !out_valid || response.ready;
    is_query   = (cmd == CMD_REPLACE) || (cmd == CMD_SWAP);
    scan_hit   = is_query && head_valid && word_hit(cmd == CMD_SWAP, head, query);
    stall      = (state == S_SCAN) && scan_hit && pend_valid && !out_free;
    advance    = ((state == S_SCAN) || (state == S_COUNT) || (state == S_MAX)) && !stall;
    do_insert  = (state == S_DONE) && out_free && (cmd == CMD_ADD) && !badlen && !present &&
                 (count != CNT_W'(CAPACITY));
    emit       = ((state == S_SCAN) && scan_hit && !stall && pend_valid) ||
                 ((state == S_DONE) && out_free);
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (cmd_t'(request.command))
            CMD_ADD, CMD_SEARCH, CMD_REPLACE, CMD_SWAP:
              state_next = in_bad ? S_DONE : S_SCAN;
            CMD_MAX_REPLACE, CMD_MAX_SWAP: state_next = S_COUNT;
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_SCAN:  if (advance && last_step) state_next = S_DONE;
      S_COUNT: if (last_step) state_next = S_MAX;
      S_MAX:   if (last_step) state_next = S_DONE;
      S_DONE:  if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    request.ready  = state == S_IDLE;
    ctrl.swap_mode = cmd == CMD_MAX_SWAP;
    ctrl.count_en  = (state == S_COUNT) && head_valid;
    key            = (state == S_COUNT) ? head : query;
    if (state == S_IDLE) begin
      ctrl.op = CELL_CLEAR;
    end else if (advance) begin
      ctrl.op = CELL_ROTATE;
    end else if (do_insert) begin
      ctrl.op = CELL_INSERT;
    end else begin
      ctrl.op = CELL_HOLD;
    end
  end

  for (genvar c = 0; c < CAPACITY; c++) begin : g_cell
    localparam int UP = (c + 1) % CAPACITY;
    localparam int DN = (c == 0) ? 0 : c - 1;
    sewd_cell #(
      .CAPACITY (CAPACITY),
      .INDEX    (c)
    ) u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .step     (step),
      .count    (count),
      .key      (key),
      .up       (cell_word[UP]),
      .up_cnt   (cell_pass[UP]),
      .down     (cell_word[DN]),
      .down_gt  ((c == 0) ? 1'b0 : cell_gt[DN]),
      .word     (cell_word[c]),
      .cnt      (cell_cnt[c]),
      .cnt_pass (cell_pass[c]),
      .gt       (cell_gt[c])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (response.ready) begin
        out_valid <= 1'b0;
      end
      if (accept) begin
        cmd        <= cmd_t'(request.command);
        query      <= query_in;
        badlen     <= in_bad;
        present    <= 1'b0;
        pend_valid <= 1'b0;
        best       <= '0;
        step       <= '0;
      end
      if (advance) step <= last_step ? '0 : step + IDX_W'(1);
      if (state == S_SCAN && !is_query && head_valid && head == query) present <= 1'b1;
      if (state == S_SCAN && scan_hit && !stall) begin
        pend       <= head;
        pend_valid <= 1'b1;
        if (pend_valid) begin
          out_status <= ST_MATCH;
          out_length <= pend.len;
          out_head   <= pend.head;
          out_tail   <= pend.tail;
          out_best   <= '0;
          out_last   <= 1'b0;
        end
      end
      if (state == S_MAX && head_valid && cell_cnt[0] > best) best <= cell_cnt[0];
      if (state == S_DONE && out_free) begin
        out_length <= pend_valid ? pend.len : '0;
        out_head   <= pend_valid ? pend.head : '0;
        out_tail   <= pend_valid ? pend.tail : '0;
        out_best   <= (cmd == CMD_MAX_REPLACE) ? 8'(best) - 8'sd1 :
                      (cmd == CMD_MAX_SWAP) ? 8'(best) : 8'sd0;
        out_last   <= 1'b1;
        pend_valid <= 1'b0;
        if (do_insert) count <= count + CNT_W'(1);
        if (badlen && (cmd == CMD_ADD || cmd == CMD_SEARCH || is_query)) begin
          out_status <= ST_BAD_LENGTH;
        end else begin
          case (cmd)
            CMD_ADD: out_status <= present ? ST_DUPLICATE :
                                   (count == CNT_W'(CAPACITY)) ? ST_FULL : ST_ADDED;
            CMD_SEARCH: out_status <= present ? ST_FOUND : ST_NOT_FOUND;
            CMD_REPLACE, CMD_SWAP: out_status <= pend_valid ? ST_MATCH : ST_NO_MATCH;
            default: out_status <= ST_COUNT;
          endcase
        end
      end
    end
  end

  assign response.valid        = out_valid;
  assign response.status       = out_status;
  assign response.match_length = out_length;
  assign response.match_head   = out_head;
  assign response.match_tail   = out_tail;
  assign response.best_count   = out_best;
  assign response.last         = out_last;

  a_busy_after_cmd: assert property (@(posedge clk) disable iff (rst)
    accept && request.command <= CMD_MAX_SWAP |=> state != S_IDLE)
    else $error("valid command left the block idle");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && count != $past(count) |-> count == $past(count) + CNT_W'(1) &&
    $past(state) == S_DONE)
    else $error("word count moved other than by one insert");

  a_pend_scope: assert property (@(posedge clk) disable iff (rst)
    pend_valid |-> state == S_SCAN || state == S_DONE)
    else $error("pending match outside a query run");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    stall |=> $stable(step))
    else $error("ring advanced during a stall");

endmodule
